// ===== rtl/sfla_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the segment free list allocator
// no dependencies

package sfla_pkg;

  localparam int NUM_SEGMENTS = 1024;
  localparam int SEG_IDX_W    = $clog2(NUM_SEGMENTS);
  localparam int SEG_CNT_W    = SEG_IDX_W + 1;
  localparam int FIELD_W      = 10;
  localparam int SPC_W        = 11;
  localparam int SPC_RESET    = 64;
  localparam int PROD_W       = FIELD_W + SPC_W + 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_POP,
    S_DIV,
    S_PUSH
  } sfla_state_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_FAIL,
    OUT_ALLOC,
    OUT_RET
  } sfla_out_sel_t;

  typedef struct packed {
    logic          init_wr;
    logic          latch;
    logic          rd_top;
    logic          div_start;
    logic          mul_load;
    logic          pop;
    logic          push;
    sfla_out_sel_t emit;
  } sfla_cmd_t;

  typedef struct packed {
    logic cmd_is_ret;
    logic list_empty;
    logic div_idle;
    logic init_last;
  } sfla_status_t;

endpackage

// ===== rtl/segment_free_list_allocator.sv =====
`timescale 1ns / 1ps
// segment free list allocator: lifo free list of segments with chunk/slot mapping
// top level; depends on sfla_pkg, sfla_ctrl, sfla_datapath
//
// a transaction is taken at a clock edge with start high and busy low.
// in_cmd 0 pops the head of the free list, in_cmd 1 pushes the segment
// in_ret_chunk * segments_per_chunk + in_ret_slot on top if in range and not full.
// each transaction gives one result, shown for one cycle with out_valid high;
// the receiver cannot stall, so results are never held back.
// allocate: the result waits for the one bit per cycle divider that splits the
// index into chunk and slot (10 steps).
// allocate on an empty list fails straight from the decode state; return: one multiply stage.
// busy falls as out_valid rises, so the next transaction can be taken at the
// edge that ends the result cycle.
// cfg_we/cfg_wdata write segments_per_chunk (reset 64, zero acts as one);
// write it only while busy is low.
// after reset a pass fills all 1024 link memory entries, one entry per cycle,
// with busy high; the list then holds every segment, highest on top.

module segment_free_list_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [sfla_pkg::FIELD_W-1:0]   in_ret_chunk,
  input  logic [sfla_pkg::FIELD_W-1:0]   in_ret_slot,
  input  logic                          cfg_we,
  input  logic [sfla_pkg::SPC_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [sfla_pkg::FIELD_W-1:0]   out_seg_index,
  output logic [sfla_pkg::FIELD_W-1:0]   out_chunk,
  output logic [sfla_pkg::FIELD_W-1:0]   out_slot,
  output logic [sfla_pkg::SEG_CNT_W-1:0] out_free_left
);
  import sfla_pkg::*;

  sfla_cmd_t    cmd;
  sfla_status_t status;

  sfla_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  sfla_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_cmd        (in_cmd),
    .in_ret_chunk  (in_ret_chunk),
    .in_ret_slot   (in_ret_slot),
    .out_valid     (out_valid),
    .out_granted   (out_granted),
    .out_seg_index (out_seg_index),
    .out_chunk     (out_chunk),
    .out_slot      (out_slot),
    .out_free_left (out_free_left)
  );

endmodule

// ===== rtl/sfla_divider.sv =====
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
// depends on sfla_pkg

module sfla_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sfla_pkg::SEG_IDX_W-1:0] dividend,
  input  logic [sfla_pkg::SPC_W-1:0]     divisor,
  output logic                          idle,
  output logic [sfla_pkg::SEG_IDX_W-1:0] quotient,
  output logic [sfla_pkg::SEG_IDX_W-1:0] remainder
);
  import sfla_pkg::*;

  localparam int REM_W  = SPC_W + 1;
  localparam int STEP_W = $clog2(SEG_IDX_W + 1);

  logic                 busy_r, busy_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [SEG_IDX_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SPC_W-1:0]     div_r, div_nxt;
  logic [REM_W-1:0]     trial;
  logic                 ge;

  always_comb begin
    trial    = {rem_r[REM_W-2:0], q_r[SEG_IDX_W-1]};
    ge       = (trial >= {1'b0, div_r});
    busy_nxt = busy_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? (trial - {1'b0, div_r}) : trial;
      q_nxt    = {q_r[SEG_IDX_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SEG_IDX_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign idle      = ~busy_r;
  assign quotient  = q_r;
  assign remainder = rem_r[SEG_IDX_W-1:0];

endmodule

// ===== rtl/sfla_datapath.sv =====
`timescale 1ns / 1ps
// datapath: link memory, head and count registers, index multiply, result registers
// depends on sfla_pkg and sfla_divider

module sfla_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfla_pkg::sfla_cmd_t           cmd,
  output sfla_pkg::sfla_status_t        status,
  input  logic                          cfg_we,
  input  logic [sfla_pkg::SPC_W-1:0]     cfg_wdata,
  input  logic                          in_cmd,
  input  logic [sfla_pkg::FIELD_W-1:0]   in_ret_chunk,
  input  logic [sfla_pkg::FIELD_W-1:0]   in_ret_slot,
  output logic                          out_valid,
  output logic                          out_granted,
  output logic [sfla_pkg::FIELD_W-1:0]   out_seg_index,
  output logic [sfla_pkg::FIELD_W-1:0]   out_chunk,
  output logic [sfla_pkg::FIELD_W-1:0]   out_slot,
  output logic [sfla_pkg::SEG_CNT_W-1:0] out_free_left
);
  import sfla_pkg::*;

  logic [SEG_IDX_W-1:0] link_mem [NUM_SEGMENTS];
  logic [SEG_IDX_W-1:0] rd_data_r;

  logic [SPC_W-1:0]     spc_r;
  logic [SPC_W-1:0]     divisor;
  logic [SEG_IDX_W-1:0] init_cnt_r;
  logic [SEG_IDX_W-1:0] top_r, top_nxt;
  logic [SEG_CNT_W-1:0] free_r, free_nxt;
  logic                 cmd_r;
  logic [FIELD_W-1:0]   rc_r;
  logic [FIELD_W-1:0]   rs_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 ret_ok;
  logic [SEG_IDX_W-1:0] ret_idx;

  logic                 wr_en;
  logic [SEG_IDX_W-1:0] wr_addr;
  logic [SEG_IDX_W-1:0] wr_data;

  logic                 div_idle;
  logic [SEG_IDX_W-1:0] quot;
  logic [SEG_IDX_W-1:0] rem;

  logic                 valid_r;
  logic                 granted_r;
  logic [FIELD_W-1:0]   seg_r;
  logic [FIELD_W-1:0]   chunk_r;
  logic [FIELD_W-1:0]   slot_r;
  logic [SEG_CNT_W-1:0] left_r;

  assign divisor = (spc_r == '0) ? SPC_W'(1) : spc_r;
  assign ret_ok  = (prod_r < PROD_W'(NUM_SEGMENTS)) && (free_r < SEG_CNT_W'(NUM_SEGMENTS));
  assign ret_idx = prod_r[SEG_IDX_W-1:0];

  sfla_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (top_r),
    .divisor   (divisor),
    .idle      (div_idle),
    .quotient  (quot),
    .remainder (rem)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = init_cnt_r;
    wr_data = (init_cnt_r == '0) ? '0 : (init_cnt_r - 1'b1);
    top_nxt = top_r;
    free_nxt = free_r;
    if (cmd.init_wr) begin
      wr_en = 1'b1;
    end else if (cmd.push && ret_ok) begin
      wr_en    = 1'b1;
      wr_addr  = ret_idx;
      wr_data  = top_r;
      top_nxt  = ret_idx;
      free_nxt = free_r + 1'b1;
    end else if (cmd.pop) begin
      top_nxt  = rd_data_r;
      free_nxt = free_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_top) begin
      rd_data_r <= link_mem[top_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r      <= SPC_W'(SPC_RESET);
      init_cnt_r <= '0;
      top_r      <= SEG_IDX_W'(NUM_SEGMENTS - 1);
      free_r     <= SEG_CNT_W'(NUM_SEGMENTS);
      valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        spc_r <= cfg_wdata;
      end
      if (cmd.init_wr) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end
      top_r   <= top_nxt;
      free_r  <= free_nxt;
      valid_r <= (cmd.emit != OUT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_cmd;
      rc_r  <= in_ret_chunk;
      rs_r  <= in_ret_slot;
    end
    if (cmd.mul_load) begin
      prod_r <= PROD_W'(rc_r) * PROD_W'(divisor) + PROD_W'(rs_r);
    end
    unique case (cmd.emit)
      OUT_FAIL: begin
        granted_r <= 1'b0;
        seg_r     <= '0;
        chunk_r   <= '0;
        slot_r    <= '0;
        left_r    <= free_r;
      end
      OUT_ALLOC: begin
        granted_r <= 1'b1;
        chunk_r   <= FIELD_W'(quot);
        slot_r    <= FIELD_W'(rem);
        left_r    <= free_r;
      end
      OUT_RET: begin
        granted_r <= ret_ok;
        seg_r     <= '0;
        chunk_r   <= '0;
        slot_r    <= '0;
        left_r    <= free_nxt;
      end
      default: begin
      end
    endcase
    if (cmd.div_start) begin
      seg_r <= FIELD_W'(top_r);
    end
  end

  assign status.cmd_is_ret = cmd_r;
  assign status.list_empty = (free_r == '0);
  assign status.div_idle   = div_idle;
  assign status.init_last  = (init_cnt_r == SEG_IDX_W'(NUM_SEGMENTS - 1));

  assign out_valid     = valid_r;
  assign out_granted   = granted_r;
  assign out_seg_index = seg_r;
  assign out_chunk     = chunk_r;
  assign out_slot      = slot_r;
  assign out_free_left = left_r;

endmodule

// ===== rtl/sfla_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: link memory init pass and command sequencing
// depends on sfla_pkg

module sfla_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  sfla_pkg::sfla_status_t status,
  output sfla_pkg::sfla_cmd_t    cmd
);
  import sfla_pkg::*;

  sfla_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = OUT_NONE;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.cmd_is_ret) begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_PUSH;
        end else if (status.list_empty) begin
          cmd.emit  = OUT_FAIL;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_top    = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (status.div_idle) begin
          cmd.emit  = OUT_ALLOC;
          state_nxt = S_IDLE;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        cmd.emit  = OUT_RET;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== tb/sv/tb_segment_free_list_allocator.sv =====
`timescale 1ns / 1ps
// testbench for segment_free_list_allocator: directed table, then random phases
// checked against an in-bench free list predictor; depends on sfla_pkg and the rtl

module tb_segment_free_list_allocator;
  import sfla_pkg::*;

  localparam logic CMD_ALLOC  = 1'b0;
  localparam logic CMD_RETURN = 1'b1;
  localparam int   KEEP_SPC   = -1;
  localparam int   MAX_REPORT = 10;
  localparam int   MAX_GAP    = 15;
  localparam int   N_DIRECTED = 20;

  typedef struct packed {
    logic                 granted;
    logic [FIELD_W-1:0]   seg_index;
    logic [FIELD_W-1:0]   chunk;
    logic [FIELD_W-1:0]   slot;
    logic [SEG_CNT_W-1:0] free_left;
  } grant_t;

  typedef struct {
    int                   spc;
    logic                 cmd;
    logic [FIELD_W-1:0]   ret_chunk;
    logic [FIELD_W-1:0]   ret_slot;
    bit                   typed;
    logic                 granted;
    logic [FIELD_W-1:0]   seg_index;
    logic [FIELD_W-1:0]   chunk;
    logic [FIELD_W-1:0]   slot;
    logic [SEG_CNT_W-1:0] free_left;
  } dir_row_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 start         = 1'b0;
  logic                 in_cmd        = CMD_ALLOC;
  logic [FIELD_W-1:0]   in_ret_chunk  = '0;
  logic [FIELD_W-1:0]   in_ret_slot   = '0;
  logic                 cfg_we        = 1'b0;
  logic [SPC_W-1:0]     cfg_wdata     = SPC_W'(SPC_RESET);
  logic                 busy;
  logic                 out_valid;
  logic                 out_granted;
  logic [FIELD_W-1:0]   out_seg_index;
  logic [FIELD_W-1:0]   out_chunk;
  logic [FIELD_W-1:0]   out_slot;
  logic [SEG_CNT_W-1:0] out_free_left;

  // predictor state
  logic [SEG_CNT_W-1:0] top_seg;
  logic [SEG_CNT_W-1:0] link_mem [NUM_SEGMENTS];
  logic [SEG_CNT_W-1:0] free_count;
  logic [SPC_W-1:0]     seg_per_chunk;

  grant_t               pending_grants [$];
  int unsigned          held_segs [$];
  int                   bad_grants = 0;
  dir_row_t             dir_rows [N_DIRECTED];

  segment_free_list_allocator u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_ret_chunk  (in_ret_chunk),
    .in_ret_slot   (in_ret_slot),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_granted   (out_granted),
    .out_seg_index (out_seg_index),
    .out_chunk     (out_chunk),
    .out_slot      (out_slot),
    .out_free_left (out_free_left)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic grant_t predict_grant(input logic cmd, input logic [FIELD_W-1:0] rc,
                                           input logic [FIELD_W-1:0] rs);
    grant_t      r;
    int unsigned div;
    int unsigned idx;
    r   = '0;
    div = (seg_per_chunk == '0) ? 1 : int'(seg_per_chunk);
    if (cmd == CMD_ALLOC) begin
      if (free_count != '0) begin
        idx        = (top_seg >= NUM_SEGMENTS) ? 0 : int'(top_seg);
        top_seg    = link_mem[idx];
        free_count = free_count - 1'b1;
        r.granted   = 1'b1;
        r.seg_index = FIELD_W'(idx);
        r.chunk     = FIELD_W'(idx / div);
        r.slot      = FIELD_W'(idx % div);
      end
    end else begin
      idx = int'(rc) * div + int'(rs);
      if (idx < NUM_SEGMENTS && free_count < NUM_SEGMENTS) begin
        link_mem[idx] = top_seg;
        top_seg       = SEG_CNT_W'(idx);
        free_count    = free_count + 1'b1;
        r.granted     = 1'b1;
      end
    end
    r.free_left = free_count;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    bad_grants++;
    if (bad_grants <= MAX_REPORT) $display("%t %s", $realtime, what);
  endtask

  // result monitor, sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin : grant_check
    grant_t want;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction: g=%0d seg=%0d chunk=%0d slot=%0d free=%0d",
                      out_granted, out_seg_index, out_chunk, out_slot, out_free_left));
      end else begin
        want = pending_grants.pop_front();
        if (out_granted !== want.granted || out_seg_index !== want.seg_index ||
            out_chunk !== want.chunk || out_slot !== want.slot ||
            out_free_left !== want.free_left) begin
          note_mismatch($sformatf({"grant mismatch: exp g=%0d seg=%0d chunk=%0d slot=%0d ",
                        "free=%0d, got g=%0d seg=%0d chunk=%0d slot=%0d free=%0d"},
                        want.granted, want.seg_index, want.chunk, want.slot, want.free_left,
                        out_granted, out_seg_index, out_chunk, out_slot, out_free_left));
        end
      end
    end
  end

  task automatic wait_all_granted();
    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_seg_per_chunk(input logic [SPC_W-1:0] value);
    wait_all_granted();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    seg_per_chunk  = value;
  endtask

  task automatic send_item(input logic cmd, input logic [FIELD_W-1:0] rc,
                           input logic [FIELD_W-1:0] rs, input bit typed, input grant_t typed_res);
    grant_t g;
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_ret_chunk <= rc;
    in_ret_slot  <= rs;
    @(posedge clk);
    while (busy) @(posedge clk);
    g = predict_grant(cmd, rc, rs);
    if (cmd == CMD_ALLOC && g.granted) held_segs.push_back(g.seg_index);
    pending_grants.push_back(typed ? typed_res : g);
  endtask

  task automatic pick_item(input int alloc_pct, output logic cmd,
                           output logic [FIELD_W-1:0] rc, output logic [FIELD_W-1:0] rs);
    int unsigned div;
    int unsigned k;
    int unsigned idx;
    div = (seg_per_chunk == '0) ? 1 : int'(seg_per_chunk);
    rc  = FIELD_W'($urandom);
    rs  = FIELD_W'($urandom);
    if ($urandom_range(99) < alloc_pct) begin
      cmd = CMD_ALLOC;
    end else begin
      cmd = CMD_RETURN;
      if (held_segs.size() != 0 && $urandom_range(99) < 85) begin
        // give back a segment that is out on loan
        k   = $urandom_range(held_segs.size() - 1);
        idx = held_segs[k];
        held_segs.delete(k);
        rc  = FIELD_W'(idx / div);
        rs  = FIELD_W'(idx % div);
      end else begin
        case ($urandom_range(2))
          0: ;
          1: begin
            rc = FIELD_W'($urandom_range(15));
            rs = FIELD_W'($urandom_range(63));
          end
          default: rs = '0;
        endcase
      end
    end
  endtask

  task automatic run_phase(input int spc, input int idle_pct, input int n_items,
                           input int alloc_pct, input bit to_empty);
    int                 done;
    int                 empty_hits;
    logic               cmd;
    logic [FIELD_W-1:0] rc;
    logic [FIELD_W-1:0] rs;
    done       = 0;
    empty_hits = 0;
    write_seg_per_chunk(SPC_W'(spc));
    while (to_empty ? (empty_hits < 40) : (done < n_items)) begin
      if (to_empty && free_count == '0) begin
        empty_hits++;
        pick_item(75, cmd, rc, rs);
      end else begin
        pick_item(alloc_pct, cmd, rc, rs);
      end
      send_item(cmd, rc, rs, 1'b0, '0);
      done++;
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
      end
    end
  endtask

  initial begin
    grant_t typed_res;
    top_seg       = SEG_CNT_W'(NUM_SEGMENTS - 1);
    free_count    = SEG_CNT_W'(NUM_SEGMENTS);
    seg_per_chunk = SPC_W'(SPC_RESET);
    link_mem[0] = '0;
    for (int i = 1; i < NUM_SEGMENTS; i++) link_mem[i] = SEG_CNT_W'(i - 1);

    dir_rows = '{
      // reset list: highest segments on top
      '{KEEP_SPC, CMD_ALLOC,  10'd0,    10'd0,    1'b1, 1'b1, 10'd1023, 10'd15, 10'd63, 11'd1023},
      '{KEEP_SPC, CMD_ALLOC,  10'd1023, 10'd1023, 1'b1, 1'b1, 10'd1022, 10'd15, 10'd62, 11'd1022},
      '{KEEP_SPC, CMD_RETURN, 10'd15,   10'd63,   1'b1, 1'b1, 10'd0,    10'd0,  10'd0,  11'd1023},
      // out of range index
      '{KEEP_SPC, CMD_RETURN, 10'd1023, 10'd1023, 1'b1, 1'b0, 10'd0,    10'd0,  10'd0,  11'd1023},
      // double free of a listed segment, still taken
      '{KEEP_SPC, CMD_RETURN, 10'd0,    10'd0,    1'b1, 1'b1, 10'd0,    10'd0,  10'd0,  11'd1024},
      // list already full
      '{KEEP_SPC, CMD_RETURN, 10'd0,    10'd1,    1'b1, 1'b0, 10'd0,    10'd0,  10'd0,  11'd1024},
      '{KEEP_SPC, CMD_ALLOC,  10'd0,    10'd0,    1'b1, 1'b1, 10'd0,    10'd0,  10'd0,  11'd1023},
      '{KEEP_SPC, CMD_ALLOC,  10'd0,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{1,        CMD_ALLOC,  10'd0,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{KEEP_SPC, CMD_RETURN, 10'd1023, 10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{1024,     CMD_ALLOC,  10'd0,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{KEEP_SPC, CMD_RETURN, 10'd1,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{KEEP_SPC, CMD_RETURN, 10'd0,    10'd1023, 1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      // zero segments per chunk acts as one
      '{0,        CMD_ALLOC,  10'd0,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{KEEP_SPC, CMD_RETURN, 10'd1023, 10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{2047,     CMD_ALLOC,  10'd0,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{KEEP_SPC, CMD_RETURN, 10'd1,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{1023,     CMD_ALLOC,  10'd0,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{KEEP_SPC, CMD_RETURN, 10'd1,    10'd0,    1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0},
      '{64,       CMD_RETURN, 10'd1023, 10'd1023, 1'b0, 1'b0, 10'd0,    10'd0,  10'd0,  11'd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // link memory fill pass runs with busy high
    do @(posedge clk); while (!busy);
    while (busy) @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (dir_rows[i].spc != KEEP_SPC) write_seg_per_chunk(SPC_W'(dir_rows[i].spc));
      typed_res = '{dir_rows[i].granted, dir_rows[i].seg_index, dir_rows[i].chunk,
                    dir_rows[i].slot, dir_rows[i].free_left};
      send_item(dir_rows[i].cmd, dir_rows[i].ret_chunk, dir_rows[i].ret_slot,
                dir_rows[i].typed, typed_res);
    end

    run_phase(1, 0, 100, 55, 1'b0);
    run_phase(1024, 54, 200, 90, 1'b0);
    run_phase(int'($urandom_range(2, 1023)), 0, 0, 97, 1'b1);
    run_phase(int'($urandom_range(1, 64)), 32, 100, 25, 1'b0);

    wait_all_granted();
    repeat (20) @(posedge clk);
    if (bad_grants == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== segment_free_list_allocator.f =====
rtl/sfla_pkg.sv
rtl/sfla_divider.sv
rtl/sfla_datapath.sv
rtl/sfla_ctrl.sv
rtl/segment_free_list_allocator.sv
tb/sv/tb_segment_free_list_allocator.sv
